[design/nts_pkg.sv]
package nts_pkg;

   // default nesting bound
   localparam int unsigned MAX_DEPTH_DEF = 255;

   typedef enum logic [3:0] {
      TK_OPEN    = 4'd0,
      TK_CLOSE   = 4'd1,
      TK_SYMBOL  = 4'd2,
      TK_STRING  = 4'd3,
      TK_NUMBER  = 4'd4,
      TK_TAG     = 4'd5,
      TK_COMMENT = 4'd6,
      TK_COMMA   = 4'd7,
      TK_SEMI    = 4'd8,
      TK_UNKNOWN = 4'd9,
      TK_LEXERR  = 4'd10,
      TK_END     = 4'd11,
      TK_NONE    = 4'd15
   } token_kind_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_EMPTY        = 4'd1,
      ST_LEXER_ERROR  = 4'd2,
      ST_INVALID      = 4'd3,
      ST_NO_OPEN      = 4'd4,
      ST_TOO_MANY_CLS = 4'd5,
      ST_BAD_CLOSE    = 4'd6,
      ST_BAD_TAG      = 4'd7,
      ST_BAD_COMMA    = 4'd8,
      ST_BAD_SEMI     = 4'd9,
      ST_MISSING_CLS  = 4'd10,
      ST_MISSING_SEMI = 4'd11,
      ST_TRAILING     = 4'd12,
      ST_DEPTH_OVF    = 4'd13
   } status_type;

   typedef enum logic [1:0] {
      NK_LABELLED = 2'd0,
      NK_LEAF     = 2'd1,
      NK_INTERNAL = 2'd2,
      NK_ROOT     = 2'd3
   } name_kind_type;

   localparam logic OUT_NODE   = 1'b0;
   localparam logic OUT_STATUS = 1'b1;

   // node flag bits
   localparam int unsigned FL_LENGTH  = 0;
   localparam int unsigned FL_TAG     = 1;
   localparam int unsigned FL_COMMENT = 2;

   // predecessor masks, one bit per token kind
   localparam logic [15:0] PM_OPEN  = 16'h00c1; // open, comment, comma
   localparam logic [15:0] PM_CLOSE = 16'h00fe; // close, label, number, tag, comment, comma
   localparam logic [15:0] PM_LABEL = 16'h00c3; // open, close, comment, comma
   localparam logic [15:0] PM_NUM   = 16'h00cf; // open, close, label, comment, comma
   localparam logic [15:0] PM_TAG   = 16'h007e; // close, label, number, tag, comment
   localparam logic [15:0] PM_CMT   = 16'h007e; // same set sets the comment flag
   localparam logic [15:0] PM_COMMA = 16'h00ff;
   localparam logic [15:0] PM_SEMI  = 16'h007e;

   typedef struct packed {
      logic           seen_token;
      logic           tree_closed;
      logic           lex_failed;
      status_type     first_error;
      logic [15:0]    first_error_pos;
      token_kind_type prev_kind;
      token_kind_type prev_solid_kind;
      logic           node_open;
      logic           open_leaf;
      logic           open_named;
      logic [15:0]    open_label_pos;
      logic [2:0]     open_flags;
   } nts_state_type;

   localparam nts_state_type STATE_RESET = '{
      seen_token:      1'b0,
      tree_closed:     1'b0,
      lex_failed:      1'b0,
      first_error:     ST_OK,
      first_error_pos: 16'd0,
      prev_kind:       TK_NONE,
      prev_solid_kind: TK_NONE,
      node_open:       1'b0,
      open_leaf:       1'b0,
      open_named:      1'b0,
      open_label_pos:  16'd0,
      open_flags:      3'd0
   };

   typedef struct packed {
      logic          out_kind;
      logic [7:0]    node_depth;
      logic          node_leaf;
      name_kind_type name_kind;
      logic [15:0]   label_position;
      logic          has_length;
      logic          has_tag;
      logic          has_comment;
      status_type    status;
      logic [15:0]   error_position;
   } nts_result_type;

   function automatic logic prev_in(input token_kind_type prev, input logic [15:0] mask);
      return mask[prev];
   endfunction

endpackage

[design/nts_step.sv]
module nts_step #(
   parameter int unsigned MAX_DEPTH = nts_pkg::MAX_DEPTH_DEF,
   parameter int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
   input  logic [3:0]             token_kind,
   input  logic [15:0]            position,
   input  nts_pkg::nts_state_type cur,
   input  logic [DEPTH_W-1:0]     cur_nest,
   input  logic [DEPTH_W-1:0]     cur_open_depth,
   output nts_pkg::nts_state_type nxt,
   output logic [DEPTH_W-1:0]     nxt_nest,
   output logic [DEPTH_W-1:0]     nxt_open_depth,
   output logic                   emit,
   output nts_pkg::nts_result_type res
);
   import nts_pkg::*;

   always_comb begin
      token_kind_type     kind;
      logic               upd;
      logic [DEPTH_W-1:0] o_depth;
      logic               o_leaf;
      logic               o_named;
      logic [15:0]        o_label;
      logic [2:0]         o_flags;
      name_kind_type      nk;

      nxt            = cur;
      nxt_nest       = cur_nest;
      nxt_open_depth = cur_open_depth;
      emit           = 1'b0;
      res            = '0;
      upd            = 1'b0;
      o_depth        = cur_open_depth;
      o_leaf         = cur.open_leaf;
      o_named        = cur.open_named;
      o_label        = cur.open_label_pos;
      o_flags        = cur.open_flags;
      nk             = NK_LABELLED;

      // reserved codes read as unknown
      if (token_kind > TK_END) begin
         kind = TK_UNKNOWN;
      end else begin
         kind = token_kind_type'(token_kind);
      end

      if (kind == TK_END) begin
         emit         = 1'b1;
         res.out_kind = OUT_STATUS;
         if (!cur.seen_token) begin
            res.status         = ST_EMPTY;
            res.error_position = position;
         end else if (cur.first_error != ST_OK && cur.first_error != ST_TRAILING) begin
            res.status         = cur.first_error;
            res.error_position = cur.first_error_pos;
         end else if (cur_nest != '0) begin
            res.status         = ST_MISSING_CLS;
            res.error_position = position;
         end else if (!cur.tree_closed) begin
            res.status         = ST_MISSING_SEMI;
            res.error_position = position;
         end else if (cur.first_error == ST_TRAILING) begin
            res.status         = ST_TRAILING;
            res.error_position = cur.first_error_pos;
         end
         nxt            = STATE_RESET;
         nxt_nest       = '0;
         nxt_open_depth = '0;
      end else begin
         nxt.seen_token = 1'b1;
         if (kind == TK_LEXERR) begin
            if (!cur.lex_failed) begin
               nxt.lex_failed      = 1'b1;
               nxt.first_error     = ST_LEXER_ERROR;
               nxt.first_error_pos = position;
            end
         end else if (cur.lex_failed || cur.first_error != ST_OK) begin
            // stream already failed
         end else if (cur.tree_closed) begin
            if (kind != TK_COMMENT) begin
               nxt.first_error     = ST_TRAILING;
               nxt.first_error_pos = position;
            end
         end else if (kind == TK_UNKNOWN) begin
            nxt.first_error     = ST_INVALID;
            nxt.first_error_pos = position;
         end else if (kind == TK_OPEN) begin
            if (cur.prev_kind != TK_NONE && !prev_in(cur.prev_kind, PM_OPEN)) begin
               nxt.first_error     = ST_INVALID;
               nxt.first_error_pos = position;
            end else if (cur_nest >= DEPTH_W'(MAX_DEPTH)) begin
               nxt.first_error     = ST_DEPTH_OVF;
               nxt.first_error_pos = position;
            end else begin
               nxt_nest = cur_nest + 1'b1;
               upd      = 1'b1;
            end
         end else if (cur.prev_kind == TK_NONE) begin
            if (kind != TK_COMMENT) begin
               nxt.first_error     = ST_NO_OPEN;
               nxt.first_error_pos = position;
            end else begin
               upd = 1'b1;
            end
         end else begin
            // open a fresh node record if none is pending
            if (!cur.node_open) begin
               o_depth = cur_nest;
               o_leaf  = (cur.prev_solid_kind == TK_OPEN) || (cur.prev_solid_kind == TK_COMMA);
               o_named = 1'b0;
               o_label = 16'd0;
               o_flags = 3'd0;
            end
            upd = 1'b1;
            case (kind)
               TK_CLOSE: begin
                  if (cur_nest == '0) begin
                     nxt.first_error = ST_TOO_MANY_CLS;
                     upd             = 1'b0;
                  end else if (!prev_in(cur.prev_kind, PM_CLOSE)) begin
                     nxt.first_error = ST_BAD_CLOSE;
                     upd             = 1'b0;
                  end else begin
                     emit     = 1'b1;
                     nk       = o_named ? NK_LABELLED : (o_leaf ? NK_LEAF : NK_INTERNAL);
                     nxt_nest = cur_nest - 1'b1;
                  end
               end
               TK_SYMBOL, TK_STRING: begin
                  if (!prev_in(cur.prev_kind, PM_LABEL)) begin
                     nxt.first_error = ST_INVALID;
                     upd             = 1'b0;
                  end else begin
                     o_named = 1'b1;
                     o_label = position;
                  end
               end
               TK_NUMBER: begin
                  if (!prev_in(cur.prev_kind, PM_NUM)) begin
                     nxt.first_error = ST_INVALID;
                     upd             = 1'b0;
                  end else begin
                     o_flags[FL_LENGTH] = 1'b1;
                  end
               end
               TK_TAG: begin
                  if (!prev_in(cur.prev_kind, PM_TAG)) begin
                     nxt.first_error = ST_BAD_TAG;
                     upd             = 1'b0;
                  end else begin
                     o_flags[FL_TAG] = 1'b1;
                  end
               end
               TK_COMMENT: begin
                  if (prev_in(cur.prev_kind, PM_CMT)) begin
                     o_flags[FL_COMMENT] = 1'b1;
                  end
               end
               TK_COMMA: begin
                  if (!prev_in(cur.prev_kind, PM_COMMA)) begin
                     nxt.first_error = ST_BAD_COMMA;
                     upd             = 1'b0;
                  end else begin
                     emit = 1'b1;
                     nk   = o_named ? NK_LABELLED : (o_leaf ? NK_LEAF : NK_INTERNAL);
                  end
               end
               default: begin
                  if (!prev_in(cur.prev_kind, PM_SEMI)) begin
                     nxt.first_error = ST_BAD_SEMI;
                     upd             = 1'b0;
                  end else begin
                     emit            = 1'b1;
                     nk              = o_named ? NK_LABELLED : NK_ROOT;
                     nxt.tree_closed = 1'b1;
                  end
               end
            endcase
            if (!upd) begin
               nxt.first_error_pos = position;
            end
            nxt.node_open      = !emit;
            nxt.open_leaf      = o_leaf;
            nxt.open_named     = o_named;
            nxt.open_label_pos = o_label;
            nxt.open_flags     = o_flags;
            nxt_open_depth     = o_depth;
            if (emit) begin
               res.out_kind       = OUT_NODE;
               res.node_depth     = 8'(o_depth);
               res.node_leaf      = o_leaf;
               res.name_kind      = nk;
               res.label_position = o_label;
               res.has_length     = o_flags[FL_LENGTH];
               res.has_tag        = o_flags[FL_TAG];
               res.has_comment    = o_flags[FL_COMMENT];
            end
         end
         if (upd) begin
            nxt.prev_kind = kind;
            if (kind != TK_COMMENT) begin
               nxt.prev_solid_kind = kind;
            end
         end
      end
   end

endmodule

[design/newick_token_syntax_checker.sv]
// channel | direction | beat contents
// req_    | in        | token_kind, position
// rsp_    | out       | out_kind, node record fields, status, error_position
//
// one token per cycle while req_ready is high: the parse state register is updated
// from the accepted token, and any node or status record lands in rsp_ regs
// a new token is taken while a record waits, as long as rsp_ready frees the slot
// synchronous active-high reset returns the parse state to empty, no record pending
// after the end token the state returns to its reset value on its own
module newick_token_syntax_checker #(
   parameter int unsigned MAX_DEPTH = nts_pkg::MAX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_token_kind,
   input  logic [15:0] req_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_node_depth,
   output logic        rsp_node_leaf,
   output logic [1:0]  rsp_name_kind,
   output logic [15:0] rsp_label_position,
   output logic        rsp_has_length,
   output logic        rsp_has_tag,
   output logic        rsp_has_comment,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_error_position
);
   import nts_pkg::*;

   // nesting counter wide enough to hold the bound itself
   localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

   nts_state_type      state_ff;
   nts_state_type      state_in;
   logic [DEPTH_W-1:0] nest_ff;
   logic [DEPTH_W-1:0] nest_in;
   logic [DEPTH_W-1:0] open_depth_ff;
   logic [DEPTH_W-1:0] open_depth_in;
   logic               rsp_valid_ff;
   nts_result_type     rsp_ff;
   nts_result_type     rsp_in;
   logic               emit;
   logic               req_accept;

   // output slot frees when empty or being drained this cycle
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   nts_step #(
      .MAX_DEPTH (MAX_DEPTH),
      .DEPTH_W   (DEPTH_W)
   ) u_step (
      .token_kind     (req_token_kind),
      .position       (req_position),
      .cur            (state_ff),
      .cur_nest       (nest_ff),
      .cur_open_depth (open_depth_ff),
      .nxt            (state_in),
      .nxt_nest       (nest_in),
      .nxt_open_depth (open_depth_in),
      .emit           (emit),
      .res            (rsp_in)
   );

   // parse state advances on every accepted token
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         nest_ff       <= '0;
         open_depth_ff <= '0;
      end else if (req_accept) begin
         state_ff      <= state_in;
         nest_ff       <= nest_in;
         open_depth_ff <= open_depth_in;
      end
   end

   // result slot: loads on an emitting token, empties when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_kind       = rsp_ff.out_kind;
   assign rsp_node_depth     = rsp_ff.node_depth;
   assign rsp_node_leaf      = rsp_ff.node_leaf;
   assign rsp_name_kind      = rsp_ff.name_kind;
   assign rsp_label_position = rsp_ff.label_position;
   assign rsp_has_length     = rsp_ff.has_length;
   assign rsp_has_tag        = rsp_ff.has_tag;
   assign rsp_has_comment    = rsp_ff.has_comment;
   assign rsp_status         = rsp_ff.status;
   assign rsp_error_position = rsp_ff.error_position;

endmodule
